@@ design/s2h_pkg.sv @@
// ----------------------------------------------------------------------------
// s2h_pkg
// Shared types and constants for the single-to-half converter.
// ----------------------------------------------------------------------------
package s2h_pkg;
  localparam int unsigned SingleWidth = 32;
  localparam int unsigned HalfWidth   = 16;
  localparam logic [7:0]  ExpMax      = 8'd255;
  localparam logic [4:0]  HalfExpInf  = 5'd31;

  typedef enum logic [1:0] {
    KIND_ZERO   = 2'd0,
    KIND_SPEC   = 2'd1,
    KIND_NORMAL = 2'd2
  } kind_t;

  // Stage 1 result: classified input with rounding mask worked out.
  typedef struct packed {
    logic        sgn;
    kind_t       kind;
    logic [9:0]  nan_frac;
    logic [7:0]  expo;
    logic [23:0] mant;
    logic [23:0] mask;
  } s1_t;

  // Stage 2 result: rounded significand.
  typedef struct packed {
    logic        sgn;
    kind_t       kind;
    logic [9:0]  nan_frac;
    logic [8:0]  expo;
    logic [23:0] mant;
  } s2_t;
endpackage

@@ design/s2h_stream_if.sv @@
// ----------------------------------------------------------------------------
// s2h_stream_if
// Valid/ready channel carrying one payload word per transfer.
// ----------------------------------------------------------------------------
interface s2h_stream_if #(
  parameter int unsigned Width = 32
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/s2h_classify.sv @@
// ----------------------------------------------------------------------------
// s2h_classify
// Decodes the single-precision fields and builds the rounding mask.
// ----------------------------------------------------------------------------
module s2h_classify import s2h_pkg::*; (
  input  logic [31:0] single_bits,
  output s1_t         res
);
  logic [7:0] expo;
  logic [4:0] sh;

  always_comb begin
    expo         = single_bits[30:23];
    sh           = 5'(expo - 8'd102);
    res.sgn      = single_bits[31];
    res.expo     = expo;
    res.mant     = {1'b1, single_bits[22:0]};
    res.nan_frac = single_bits[22:13] | {(single_bits[22:0] != 23'd0), 9'd0};
    if (expo == 8'd0) begin
      res.kind = KIND_ZERO;
    end else if (expo == ExpMax) begin
      res.kind = KIND_SPEC;
    end else begin
      res.kind = KIND_NORMAL;
    end
    if (expo < 8'd102) begin
      res.mask = 24'hFFFFFF;
    end else if (expo < 8'd113) begin
      res.mask = 24'hFFFFFF >> sh;
    end else begin
      res.mask = 24'h001FFF;
    end
  end
endmodule

@@ design/s2h_round.sv @@
// ----------------------------------------------------------------------------
// s2h_round
// Rounds the significand to nearest, ties to even, at the mask position.
// ----------------------------------------------------------------------------
module s2h_round import s2h_pkg::*; (
  input  s1_t in_s,
  output s2_t res
);
  logic [23:0] tail;
  logic [23:0] half;
  logic [23:0] add;
  logic [24:0] sum;

  always_comb begin
    tail         = in_s.mant & in_s.mask;
    half         = 24'((25'(in_s.mask) + 25'd1) >> 1);
    add          = (tail == half) ? (in_s.mant & {half[22:0], 1'b0}) : half;
    sum          = 25'(in_s.mant) + ((tail != 24'd0) ? 25'(add) : 25'd0);
    res.sgn      = in_s.sgn;
    res.kind     = in_s.kind;
    res.nan_frac = in_s.nan_frac;
    if (sum[24]) begin
      res.mant = sum[24:1];
      res.expo = 9'(in_s.expo) + 9'd1;
    end else begin
      res.mant = sum[23:0];
      res.expo = 9'(in_s.expo);
    end
  end
endmodule

@@ design/s2h_pack.sv @@
// ----------------------------------------------------------------------------
// s2h_pack
// Packs the rounded value into a half-precision pattern.
// ----------------------------------------------------------------------------
module s2h_pack import s2h_pkg::*; (
  input  s2_t         in_s,
  output logic [15:0] half_bits
);
  logic [23:0] sm;
  logic [8:0]  sh;

  always_comb begin
    sh = 9'd113 - in_s.expo;
    sm = (sh > 9'd24) ? 24'd0 : (in_s.mant >> sh[4:0]);
    unique case (in_s.kind)
      KIND_ZERO: half_bits = {in_s.sgn, 15'd0};
      KIND_SPEC: half_bits = {in_s.sgn, HalfExpInf, in_s.nan_frac};
      KIND_NORMAL: begin
        if (in_s.expo > 9'd142) begin
          half_bits = {in_s.sgn, HalfExpInf, 10'd0};
        end else if (in_s.expo < 9'd113) begin
          half_bits = {in_s.sgn, 15'(sm[23:13])};
        end else begin
          half_bits = {in_s.sgn, 15'({5'(in_s.expo - 9'd113), 10'd0} + 15'(in_s.mant[23:13]))};
        end
      end
      default: half_bits = {in_s.sgn, 15'd0};
    endcase
  end
endmodule

@@ design/single_to_half_converter_unit.sv @@
// ----------------------------------------------------------------------------
// single_to_half_converter_unit
// Three-stage pipelined binary32 to binary16 converter.
// ----------------------------------------------------------------------------
// Channel  Role    Payload
// src      sink    single_bits [31:0]
// dst      source  half_bits   [15:0]
// One transfer per cycle is accepted while dst is not stalled; results pass through the s1, s2 and h registers.
// Each stage holds a valid bit and advances when the next stage is free.
// A stall holds each occupied stage with no free stage ahead; nothing is lost or repeated.
// Reset clears the valid bits only.
module single_to_half_converter_unit import s2h_pkg::*; (
  input logic          clk,
  input logic          rst,
  s2h_stream_if.sink   src,
  s2h_stream_if.source dst
);
  s1_t         s1_d, s1;
  s2_t         s2_d, s2;
  logic [15:0] h_d, h;
  logic        v1, v2, v3;
  logic        en1, en2, en3;

  s2h_classify u_cls (.single_bits(src.data), .res(s1_d));
  s2h_round    u_rnd (.in_s(s1), .res(s2_d));
  s2h_pack     u_pck (.in_s(s2), .half_bits(h_d));

  assign en3       = !v3 || dst.ready;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign src.ready = en1;
  assign dst.valid = v3;
  assign dst.data  = h;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= src.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_d;
    if (en2) s2 <= s2_d;
    if (en3) h  <= h_d;
  end
endmodule

@@ design/s2h_checker.sv @@
// ----------------------------------------------------------------------------
// s2h_checker
// Port-level checks for the single-to-half converter.
// ----------------------------------------------------------------------------
module s2h_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_data
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed during stall");
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input refused while output drains");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after three cycles");
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");
endmodule

bind single_to_half_converter_unit s2h_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(src.valid), .in_ready(src.ready),
  .out_valid(dst.valid), .out_ready(dst.ready), .out_data(dst.data)
);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the single-to-half converter. Directed binary32 patterns cover
// zeros, subnormals, infinities, NaNs, rounding ties and carries and overflow;
// random patterns follow. A local predictor computes each expected binary16
// pattern, and every output transfer is compared with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import s2h_pkg::*;

  logic clk;
  logic rst;

  s2h_stream_if #(.Width(SingleWidth)) src_if ();
  s2h_stream_if #(.Width(HalfWidth))   dst_if ();

  single_to_half_converter_unit u_dut (
    .clk(clk),
    .rst(rst),
    .src(src_if.sink),
    .dst(dst_if.source)
  );

  localparam int unsigned WatchdogLimit = 20000;

  logic [31:0] pending_singles[$];
  logic [15:0] expected_halves[$];
  int unsigned error_count;
  int unsigned transfers_in;
  int unsigned transfers_out;
  int unsigned idle_cycles;
  int unsigned hold_left;
  bit          hold_done;
  bit          no_idle;
  bit          send_pause;
  bit          sending_done;

  function automatic logic [15:0] single_to_half(input logic [31:0] a);
    logic [7:0]  expo;
    logic [22:0] frac;
    logic        sgn;
    int          e;
    int          sh;
    logic [24:0] m;
    logic [24:0] mask;
    logic [24:0] tail;
    logic [24:0] add;
    logic [4:0]  he;
    expo = a[30:23];
    frac = a[22:0];
    sgn  = a[31];
    if (expo == 8'd0) return {sgn, 15'd0};
    if (expo == ExpMax) begin
      if (frac != 23'd0) frac[22] = 1'b1;
      return {sgn, HalfExpInf, frac[22:13]};
    end
    e = int'(expo) - 127;
    m = {2'b01, frac};
    if (e < -25) mask = 25'hFFFFFF;
    else if (e < -14) mask = 25'hFFFFFF >> (e + 25);
    else mask = 25'h1FFF;
    tail = m & mask;
    if (tail != 0) begin
      add = (mask + 25'd1) >> 1;
      if (tail == add) add = m & (add << 1);
      m = m + add;
      if (m >= 25'h1000000) begin
        m = m >> 1;
        e++;
      end
    end
    if (e > 15) return {sgn, HalfExpInf, 10'd0};
    if (e < -14) begin
      sh = -14 - e;
      m = (sh > 24) ? 25'd0 : (m >> sh);
      he = 5'd0;
    end else begin
      he = 5'(e + 14);
    end
    return {sgn, 15'({10'd0, he} << 10) + 15'(m >> 13)};
  endfunction

  task automatic report_mismatch(input string what);
    $display("tb: mismatch: %s", what);
    error_count++;
  endtask

  function automatic logic [31:0] random_single();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: v[30:23] = 8'(112 + $urandom_range(0, 34));
      1: v[30:23] = 8'(97 + $urandom_range(0, 16));
      2: v[12:0] = ($urandom_range(0, 1) != 0) ? 13'h1000 : 13'h0FFF;
      3: v[30:23] = ($urandom_range(0, 1) != 0) ? ExpMax : 8'd0;
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    logic [31:0] directed[$];
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
                 32'h7F80_0000, 32'hFF80_0000, 32'h7F80_0001, 32'hFFFF_FFFF,
                 32'h7FC0_0000, 32'h3F80_0000, 32'h477F_E000, 32'h477F_F000,
                 32'h477F_EFFF, 32'h4780_0000, 32'h3880_0000, 32'h387F_F000,
                 32'h3380_0000, 32'h3380_0001, 32'h3300_0000, 32'h0080_0000,
                 32'h3F80_1000, 32'h3F80_3000, 32'h7F7F_FFFF, 32'hB8FF_FFFF,
                 32'h3555_5555};
    foreach (directed[i]) pending_singles.push_back(directed[i]);
    for (int i = 0; i < 400; i++) pending_singles.push_back(random_single());
    wait (pending_singles.size() == 0);
    send_pause = 1'b1;
    wait (expected_halves.size() == 0);
    @(posedge clk);
    send_pause = 1'b0;
    for (int i = 0; i < 400; i++) pending_singles.push_back(random_single());
    sending_done = 1'b1;
  end

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      src_if.valid <= 1'b0;
      src_if.data  <= '0;
    end else begin
      if (src_if.valid && src_if.ready) transfers_in++;
      if (!(src_if.valid && !src_if.ready)) begin
        if (pending_singles.size() != 0 && !send_pause &&
            (no_idle || $urandom_range(0, 99) >= 7)) begin
          src_if.data  <= pending_singles[0];
          src_if.valid <= 1'b1;
          expected_halves.push_back(single_to_half(pending_singles.pop_front()));
        end else begin
          src_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver.
  always @(posedge clk) begin
    if (rst) begin
      dst_if.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (dst_if.valid && dst_if.ready) begin
        transfers_out++;
        if (expected_halves.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", dst_if.data));
        end else if (dst_if.data !== expected_halves[0]) begin
          report_mismatch($sformatf("got %h expected %h", dst_if.data, expected_halves[0]));
          void'(expected_halves.pop_front());
        end else begin
          void'(expected_halves.pop_front());
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        dst_if.ready <= 1'b0;
      end else if (!hold_done && transfers_in >= 100) begin
        hold_left <= 60;
        hold_done <= 1'b1;
        dst_if.ready <= 1'b0;
      end else begin
        dst_if.ready <= no_idle || $urandom_range(0, 99) >= 7;
      end
    end
  end

  always @(posedge clk) begin
    no_idle <= transfers_in >= 450 && transfers_in < 600;
    if (rst || (src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb: watchdog expired");
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    error_count  = 0;
    transfers_in = 0;
    transfers_out = 0;
    idle_cycles  = 0;
    no_idle      = 1'b0;
    send_pause   = 1'b0;
    sending_done = 1'b0;
    src_if.valid = 1'b0;
    src_if.data  = '0;
    dst_if.ready = 1'b0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (sending_done && pending_singles.size() == 0 && expected_halves.size() == 0);
    repeat (10) @(posedge clk);
    $display("tb: %0d patterns converted and checked, including special values", transfers_out);
    $display("tb: a long output stall and a full drain pause were exercised");
    if (error_count == 0 && expected_halves.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
